// File: rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

  localparam int DEF_MAX_JOBS  = 8;
  localparam int DEF_TIME_BITS = 32;

  localparam logic [31:0] MAX_SLEEP_RST = 32'd100;

  // Configuration register indexes.
  localparam logic CFG_MAX_SLEEP = 1'b0;
  localparam logic CFG_RUNNING   = 1'b1;

  // Outcome codes of a report; both failure codes are treated alike.
  localparam logic [1:0] OUTC_SUCCESS     = 2'd0;
  localparam logic [1:0] OUTC_PENDING     = 2'd1;
  localparam logic [1:0] OUTC_FAILURE     = 2'd2;
  localparam logic [1:0] OUTC_FAILURE_ALT = 2'd3;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_POLL     = 2'd1,
    CMD_REPORT   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REG_ACK = 2'd0,
    KIND_SERVICE = 2'd1,
    KIND_SLEEP   = 2'd2,
    KIND_REP_ACK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MARK_NONE    = 2'd0,
    MARK_INIT    = 2'd1,
    MARK_SUCCESS = 2'd2,
    MARK_FAIL    = 2'd3
  } mark_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REG,
    S_POLL,
    S_POLL_END,
    S_REP_RD,
    S_REP_CALC,
    S_REP_DIV,
    S_REP_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/pps_job_mem.sv
`default_nettype none

// Job table: one synchronous memory, one write and one read port,
// registered read data.
module pps_job_mem #(
  parameter int DEPTH = pps_pkg::DEF_MAX_JOBS,
  parameter int W     = 4 * pps_pkg::DEF_TIME_BITS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/pps_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. Only the remainder is kept.
module pps_div #(
  parameter int W = pps_pkg::DEF_TIME_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic      [W-1:0] rem
);

  localparam int CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W:0]      acc;
  logic [W-1:0]    dvd;
  logic [W-1:0]    dsr;
  logic [W:0]      shifted;
  logic            sub_ok;

  assign shifted = {acc[W-1:0], dvd[W-1]};
  assign sub_ok  = shifted >= {1'b0, dsr};
  assign rem     = acc[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        acc <= sub_ok ? (shifted - {1'b0, dsr}) : shifted;
        dvd <= {dvd[W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/periodic_poll_scheduler_top.sv
`default_nettype none

// Periodic poll scheduler. Holds a table of periodic jobs and answers one
// command beat on the input channel with exactly one result beat on the
// output channel (command code three is dropped without a result).
// Both channels use valid/ready; a beat moves when both are high.
// A register command stores a new job while the scheduler is stopped.
// A poll command scans the table and returns the earliest due job, or a
// sleep time when nothing is due. A report command applies a job outcome
// and computes its next due time, skipping missed periods.
// A poll does one table read per cycle through the memory read port, and
// a report waits for the bit-serial remainder unit to finish its work.
// One command is worked on at a time; the next command beat is taken as
// soon as the block is back in idle, even while the previous result still
// waits in the output register. If the receiver stalls, the result holds
// and a finished next result waits until the output register frees up.
// Reset clears the job count, the flags and the configuration (max_sleep
// 100, running 0); the table memory itself is not cleared.
// The configuration port writes max_sleep or running.
module periodic_poll_scheduler_top #(
  parameter int MAX_JOBS  = pps_pkg::DEF_MAX_JOBS,
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] now,
  input  wire logic [31:0] period,
  input  wire logic [31:0] phase,
  input  wire logic [31:0] job_timeout,
  input  wire logic [2:0]  slot,
  input  wire logic [1:0]  outcome,
  input  wire logic [31:0] deadline,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic             accepted,
  output logic [2:0]       job_index,
  output logic             do_init,
  output logic [31:0]      service_timeout,
  output logic [31:0]      sleep_time,
  output logic [1:0]       mark,
  output logic [31:0]      next_due
);

  localparam int T    = TIME_BITS;
  localparam int AW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW   = $clog2(MAX_JOBS + 1);
  localparam int CMPW = (CW > 3) ? CW : 3;
  // Entry layout: period, timeout, due time, cycle start.
  localparam int EW   = 3 * T + 32;
  localparam int CS_LO  = 0;
  localparam int DUE_LO = T;
  localparam int TMO_LO = 2 * T;
  localparam int PER_LO = 2 * T + 32;

  pps_pkg::state_t state, state_next;

  // Configuration.
  logic [31:0] max_sleep;
  logic        running;

  // Table bookkeeping.
  logic [CW-1:0]       job_count;
  logic [MAX_JOBS-1:0] init_done;
  logic [MAX_JOBS-1:0] pending;

  // Latched command.
  logic [T-1:0] r_now, r_per, r_phase, r_deadline;
  logic [31:0] r_tmo;
  logic [2:0]  r_slot;
  logic [1:0]  r_outcome;

  // Memory ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  // Scan state.
  logic [CW-1:0] scan_idx;
  logic          scan_dv;
  logic [AW-1:0] cmp_idx;
  logic          found;
  logic [AW-1:0] best_idx;
  logic [T-1:0]  best_due;
  logic [31:0]   best_tmo;
  logic [31:0]   minw;

  // Report working entry.
  logic [T-1:0] e_per, e_due, e_cs;
  logic [31:0]  e_tmo;

  // Result waiting for the output register.
  logic [1:0]  res_kind;
  logic        res_acc;
  logic [2:0]  res_idx;
  logic        res_init;
  logic [31:0] res_tmo;
  logic [31:0] res_sleep;
  logic [1:0]  res_mark;
  logic [31:0] res_due;

  logic         div_start, div_done;
  logic [T-1:0] div_dividend, div_divisor, div_rem;

  logic         accept;
  logic         slot_ok_in;
  logic         reg_ok;
  logic [AW-1:0] slot_a;
  logic [T-1:0] d_per, d_due, d_cs;
  logic [31:0]  d_tmo;
  logic [T-1:0] cs_sel;
  logic [T-1:0] late, ahead;
  logic         is_due, is_earlier;

  assign accept     = in_valid & in_ready;
  assign slot_ok_in = CMPW'(slot) < CMPW'(job_count);
  assign reg_ok     = !running && (job_count != CW'(MAX_JOBS)) && (r_per != '0);
  assign slot_a     = AW'(r_slot);

  assign d_cs  = mem_rdata[CS_LO +: T];
  assign d_due = mem_rdata[DUE_LO +: T];
  assign d_tmo = mem_rdata[TMO_LO +: 32];
  assign d_per = mem_rdata[PER_LO +: T];

  // Wrap-around due tests use the sign of the difference.
  assign late       = r_now - d_due;
  assign ahead      = best_due - d_due;
  assign is_due     = !late[T-1];
  assign is_earlier = !found || !ahead[T-1];

  assign cs_sel       = pending[slot_a] ? d_cs : d_due;
  assign div_dividend = r_now - cs_sel;
  assign div_divisor  = (d_per == '0) ? T'(1) : d_per;

  pps_job_mem #(.DEPTH(MAX_JOBS), .W(EW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pps_div #(.W(T)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    div_start  = 1'b0;
    case (state)
      pps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (command)
            pps_pkg::CMD_REGISTER: state_next = pps_pkg::S_REG;
            pps_pkg::CMD_POLL:     state_next = pps_pkg::S_POLL;
            pps_pkg::CMD_REPORT:   state_next = slot_ok_in ? pps_pkg::S_REP_RD
                                                           : pps_pkg::S_DONE;
            default:               state_next = pps_pkg::S_IDLE;
          endcase
        end
      end
      pps_pkg::S_REG: begin
        mem_we    = reg_ok;
        mem_waddr = job_count[AW-1:0];
        mem_wdata = {r_per, r_tmo, T'(r_now + r_phase), T'(0)};
        state_next = pps_pkg::S_DONE;
      end
      pps_pkg::S_POLL: begin
        mem_raddr = scan_idx[AW-1:0];
        if (scan_idx == job_count && !scan_dv) begin
          state_next = pps_pkg::S_POLL_END;
        end
      end
      pps_pkg::S_POLL_END: state_next = pps_pkg::S_DONE;
      pps_pkg::S_REP_RD: begin
        mem_raddr  = slot_a;
        state_next = pps_pkg::S_REP_CALC;
      end
      pps_pkg::S_REP_CALC: begin
        if (init_done[slot_a] && r_outcome != pps_pkg::OUTC_PENDING) begin
          div_start  = 1'b1;
          state_next = pps_pkg::S_REP_DIV;
        end else begin
          state_next = pps_pkg::S_REP_WR;
        end
      end
      pps_pkg::S_REP_DIV: begin
        if (div_done) begin
          state_next = pps_pkg::S_REP_WR;
        end
      end
      pps_pkg::S_REP_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = slot_a;
        mem_wdata  = {e_per, e_tmo, e_due, e_cs};
        state_next = pps_pkg::S_DONE;
      end
      pps_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = pps_pkg::S_IDLE;
        end
      end
      default: state_next = pps_pkg::S_IDLE;
    endcase
  end

  // Configuration, bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sleep <= pps_pkg::MAX_SLEEP_RST;
      running   <= 1'b0;
      job_count <= '0;
      init_done <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pps_pkg::CFG_MAX_SLEEP: max_sleep <= cfg_data;
          pps_pkg::CFG_RUNNING:   running   <= cfg_data[0];
          default:                running   <= running;
        endcase
      end
      if (state == pps_pkg::S_REG && reg_ok) begin
        job_count                      <= job_count + 1'b1;
        init_done[job_count[AW-1:0]]   <= 1'b0;
        pending[job_count[AW-1:0]]     <= 1'b0;
      end
      if (state == pps_pkg::S_REP_CALC) begin
        if (!init_done[slot_a]) begin
          if (r_outcome == pps_pkg::OUTC_SUCCESS) begin
            init_done[slot_a] <= 1'b1;
          end
        end else begin
          pending[slot_a] <= (r_outcome == pps_pkg::OUTC_PENDING);
        end
      end
      if (state == pps_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; none of these need a reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_now      <= now[T-1:0];
      r_per      <= period[T-1:0];
      r_phase    <= phase[T-1:0];
      r_tmo      <= job_timeout;
      r_slot     <= slot;
      r_outcome  <= outcome;
      r_deadline <= deadline[T-1:0];
      scan_idx   <= '0;
      scan_dv    <= 1'b0;
      found      <= 1'b0;
      minw       <= max_sleep;
      res_acc    <= 1'b0;
      res_idx    <= '0;
      res_init   <= 1'b0;
      res_tmo    <= '0;
      res_sleep  <= '0;
      res_mark   <= pps_pkg::MARK_NONE;
      res_due    <= '0;
      case (command)
        pps_pkg::CMD_REGISTER: res_kind <= pps_pkg::KIND_REG_ACK;
        pps_pkg::CMD_POLL:     res_kind <= pps_pkg::KIND_SLEEP;
        default:               res_kind <= pps_pkg::KIND_REP_ACK;
      endcase
    end

    case (state)
      pps_pkg::S_REG: begin
        if (reg_ok) begin
          res_acc <= 1'b1;
          res_idx <= 3'(job_count[AW-1:0]);
          res_due <= 32'(T'(r_now + r_phase));
        end
      end
      pps_pkg::S_POLL: begin
        if (scan_idx != job_count) begin
          scan_idx <= scan_idx + 1'b1;
          cmp_idx  <= scan_idx[AW-1:0];
          scan_dv  <= 1'b1;
        end else begin
          scan_dv <= 1'b0;
        end
        if (scan_dv) begin
          // A tie goes to the later slot, since equal times count as earlier.
          if (is_due && is_earlier) begin
            found    <= 1'b1;
            best_idx <= cmp_idx;
            best_due <= d_due;
            best_tmo <= d_tmo;
          end
          if (32'(T'(d_due - r_now)) < minw) begin
            minw <= 32'(T'(d_due - r_now));
          end
        end
      end
      pps_pkg::S_POLL_END: begin
        if (found) begin
          res_kind <= pps_pkg::KIND_SERVICE;
          res_idx  <= 3'(best_idx);
          res_init <= !init_done[best_idx];
          res_tmo  <= best_tmo;
        end else begin
          res_sleep <= (minw == '0) ? 32'd1 : minw;
        end
      end
      pps_pkg::S_REP_CALC: begin
        e_per   <= d_per;
        e_tmo   <= d_tmo;
        res_acc <= 1'b1;
        if (!init_done[slot_a]) begin
          e_due    <= d_due + d_per;
          e_cs     <= d_cs;
          res_mark <= (r_outcome == pps_pkg::OUTC_SUCCESS) ? pps_pkg::MARK_INIT
                                                           : pps_pkg::MARK_FAIL;
        end else begin
          e_cs <= cs_sel;
          if (r_outcome == pps_pkg::OUTC_PENDING) begin
            e_due    <= r_deadline;
            res_mark <= pps_pkg::MARK_NONE;
          end else begin
            e_due    <= d_due;
            res_mark <= (r_outcome == pps_pkg::OUTC_SUCCESS) ? pps_pkg::MARK_SUCCESS
                                                             : pps_pkg::MARK_FAIL;
          end
        end
      end
      pps_pkg::S_REP_DIV: begin
        // Next period point after now: cycle start plus (missed + 1) periods,
        // which equals now minus the remainder plus one period.
        if (div_done) begin
          e_due <= r_now - div_rem + e_per;
        end
      end
      pps_pkg::S_REP_WR: begin
        res_due <= 32'(e_due);
      end
      default: begin
      end
    endcase

    if (state == pps_pkg::S_DONE && (!out_valid || out_ready)) begin
      kind            <= res_kind;
      accepted        <= res_acc;
      job_index       <= res_idx;
      do_init         <= res_init;
      service_timeout <= res_tmo;
      sleep_time      <= res_sleep;
      mark            <= res_mark;
      next_due        <= res_due;
    end
  end

endmodule

`default_nettype wire

// File: bench/periodic_poll_scheduler_top_test.sv
`timescale 1ns / 1ps

// One expected result beat of the scheduler.
typedef struct packed {
  logic [1:0]  kind;
  logic        accepted;
  logic [2:0]  job_index;
  logic        do_init;
  logic [31:0] service_timeout;
  logic [31:0] sleep_time;
  logic [1:0]  mark;
  logic [31:0] next_due;
} sched_result_t;

// Shadow of the job table plus the queue of results still owed by the block.
class sched_scoreboard;
  logic [31:0] sleep_cap;
  logic        run_flag;
  logic [31:0] per_tab [8];
  logic [31:0] tmo_tab [8];
  logic [31:0] due_tab [8];
  logic [31:0] start_tab [8];
  logic        init_tab [8];
  logic        pend_tab [8];
  int          njobs;
  sched_result_t owed [$];
  int          errors;

  function new();
    sleep_cap = 32'd100;
    run_flag = 1'b0;
    njobs = 0;
    errors = 0;
    for (int i = 0; i < 8; i++) begin
      init_tab[i] = 1'b0;
      pend_tab[i] = 1'b0;
    end
  endfunction

  // A time a has reached b when the wrapped difference is non-negative.
  function bit has_reached(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31] == 1'b0;
  endfunction

  function void write_reg(logic idx, logic [31:0] data);
    if (idx == pps_pkg::CFG_MAX_SLEEP) sleep_cap = data;
    else run_flag = data[0];
  endfunction

  // Apply one accepted command beat and queue the result it causes.
  function void note_command(logic [1:0] cmd, logic [31:0] t, logic [31:0] per,
                             logic [31:0] ph, logic [31:0] tmo, logic [2:0] sl,
                             logic [1:0] oc, logic [31:0] dl);
    sched_result_t r;
    int best;
    logic [31:0] minw, w, p, elapsed, missed;
    r = '0;
    best = -1;
    if (cmd == pps_pkg::CMD_NONE) return;
    if (cmd == pps_pkg::CMD_REGISTER) begin
      r.kind = pps_pkg::KIND_REG_ACK;
      if (!run_flag && njobs < 8 && per != 0) begin
        per_tab[njobs] = per;
        tmo_tab[njobs] = tmo;
        due_tab[njobs] = t + ph;
        start_tab[njobs] = '0;
        init_tab[njobs] = 1'b0;
        pend_tab[njobs] = 1'b0;
        r.accepted = 1'b1;
        r.job_index = njobs[2:0];
        r.next_due = t + ph;
        njobs++;
      end
    end else if (cmd == pps_pkg::CMD_POLL) begin
      for (int i = 0; i < njobs; i++)
        if (has_reached(t, due_tab[i]) &&
            (best < 0 || has_reached(due_tab[best], due_tab[i])))
          best = i;
      if (best >= 0) begin
        r.kind = pps_pkg::KIND_SERVICE;
        r.job_index = best[2:0];
        r.do_init = !init_tab[best];
        r.service_timeout = tmo_tab[best];
      end else begin
        minw = sleep_cap;
        for (int i = 0; i < njobs; i++) begin
          w = due_tab[i] - t;
          if (w < minw) minw = w;
        end
        r.kind = pps_pkg::KIND_SLEEP;
        r.sleep_time = (minw == 0) ? 32'd1 : minw;
      end
    end else begin
      r.kind = pps_pkg::KIND_REP_ACK;
      if (sl < njobs) begin
        r.accepted = 1'b1;
        if (!init_tab[sl]) begin
          if (oc == pps_pkg::OUTC_SUCCESS) begin
            init_tab[sl] = 1'b1;
            r.mark = pps_pkg::MARK_INIT;
          end else begin
            r.mark = pps_pkg::MARK_FAIL;
          end
          due_tab[sl] = due_tab[sl] + per_tab[sl];
        end else begin
          if (!pend_tab[sl]) start_tab[sl] = due_tab[sl];
          if (oc == pps_pkg::OUTC_PENDING) begin
            pend_tab[sl] = 1'b1;
            due_tab[sl] = dl;
            r.mark = pps_pkg::MARK_NONE;
          end else begin
            pend_tab[sl] = 1'b0;
            r.mark = (oc == pps_pkg::OUTC_SUCCESS) ? pps_pkg::MARK_SUCCESS
                                                   : pps_pkg::MARK_FAIL;
            p = per_tab[sl];
            elapsed = t - start_tab[sl];
            missed = elapsed / p;
            due_tab[sl] = start_tab[sl] + (missed + 32'd1) * p;
          end
        end
        r.next_due = due_tab[sl];
      end
    end
    owed.push_back(r);
  endfunction

  function void check_result(sched_result_t got);
    sched_result_t e;
    if (owed.size() == 0) begin
      $display("%0t: result beat with nothing expected: %p", $time, got);
      errors++;
      return;
    end
    e = owed.pop_front();
    if (got.kind !== e.kind) report_field("kind", e.kind, got.kind);
    if (got.accepted !== e.accepted) report_field("accepted", e.accepted, got.accepted);
    if (got.job_index !== e.job_index) report_field("job_index", e.job_index, got.job_index);
    if (got.do_init !== e.do_init) report_field("do_init", e.do_init, got.do_init);
    if (got.service_timeout !== e.service_timeout)
      report_field("service_timeout", e.service_timeout, got.service_timeout);
    if (got.sleep_time !== e.sleep_time)
      report_field("sleep_time", e.sleep_time, got.sleep_time);
    if (got.mark !== e.mark) report_field("mark", e.mark, got.mark);
    if (got.next_due !== e.next_due) report_field("next_due", e.next_due, got.next_due);
  endfunction

  function void report_field(string name, logic [31:0] e, logic [31:0] g);
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, g);
    errors++;
  endfunction
endclass

module periodic_poll_scheduler_top_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [31:0] now = '0;
  logic [31:0] period = '0;
  logic [31:0] phase = '0;
  logic [31:0] job_timeout = '0;
  logic [2:0]  slot = '0;
  logic [1:0]  outcome = '0;
  logic [31:0] deadline = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic        accepted;
  logic [2:0]  job_index;
  logic        do_init;
  logic [31:0] service_timeout;
  logic [31:0] sleep_time;
  logic [1:0]  mark;
  logic [31:0] next_due;

  sched_scoreboard board = new();

  // Simulated millisecond clock that the command beats carry.
  logic [31:0] tick;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit          hold_request = 1'b0;
  bit          sink_random = 1'b1;
  longint      cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  periodic_poll_scheduler_top dut (.*);

  // The cycle counter bounds the whole run. The slowest correct run is about
  // 1500 beats times the report latency plus long stalls on both sides.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("** periodic_poll_scheduler_top: FAILED **");
      $finish;
    end
  end

  // Output side: every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result('{kind, accepted, job_index, do_init, service_timeout,
                           sleep_time, mark, next_due});
  end

  // Receiver: random stalls, mostly short with occasional long ones, plus a
  // single long hold-off when the stimulus asks for it.
  initial begin : receiver
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end
      if (!sink_random || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic write_cfg(logic idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  // Wait until every owed result has come, then keep idling so that a
  // dropped command three cannot still be in flight.
  task automatic drain();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Offer one command beat and hold it until the block takes it.
  task automatic send_beat(logic [1:0] cmd, logic [31:0] t, logic [31:0] per,
                           logic [31:0] ph, logic [31:0] tmo, logic [2:0] sl,
                           logic [1:0] oc, logic [31:0] dl);
    command <= cmd;
    now <= t;
    period <= per;
    phase <= ph;
    job_timeout <= tmo;
    slot <= sl;
    outcome <= oc;
    deadline <= dl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(cmd, t, per, ph, tmo, sl, oc, dl);
  endtask

  // Random idle gap on the sender side, sometimes none at all.
  task automatic sender_gap(bit allow);
    int n;
    if (!allow || $urandom_range(0, 1) == 0) return;
    n = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers random jobs into the table; periods are mostly small so the
  // jobs come due often, with a few huge ones to stress the wrap.
  task automatic load_table(int count);
    logic [31:0] per;
    write_cfg(pps_pkg::CFG_RUNNING, 32'd0);
    for (int i = 0; i < count; i++) begin
      per = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 200);
      send_beat(pps_pkg::CMD_REGISTER, tick, per, $urandom_range(0, 50), $urandom,
                3'd0, pps_pkg::OUTC_SUCCESS, 32'd0);
    end
    go_idle();
  endtask

  // One scheduler round: poll, then report on a random slot, mostly a registered
  // one, with a random outcome; now advances between polls.
  task automatic poll_round(bit gaps);
    logic [1:0] oc;
    int pick;
    tick = tick + $urandom_range(0, 40);
    send_beat(pps_pkg::CMD_POLL, tick, $urandom, $urandom, $urandom, 3'($urandom),
              2'($urandom), $urandom);
    sender_gap(gaps);
    oc = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0)
      send_beat(pps_pkg::CMD_REPORT, tick, $urandom, $urandom, $urandom,
                3'($urandom), oc, $urandom);
    else
      send_beat(pps_pkg::CMD_REPORT, tick, $urandom, $urandom, $urandom,
                3'($urandom_range(0, (board.njobs > 0) ? board.njobs - 1 : 0)), oc,
                tick + $urandom_range(0, 30));
    sender_gap(gaps);
  endtask

  // The block keeps its job count until a reset, and the stimulus resets it
  // only once, at the start, so a new table would need a fresh reset.
  // Instead the table is filled once and stays.
  initial begin : stimulus
    tick = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a poll on the empty table sleeps the reset cap, zero period
    // is refused, and an unregistered slot report is ignored.
    send_beat(pps_pkg::CMD_POLL, tick, '0, '0, '0, '0, '0, '0);
    send_beat(pps_pkg::CMD_REGISTER, tick, 32'd0, 32'd5, 32'hFFFF_FFFF, 3'd7,
              pps_pkg::OUTC_SUCCESS, '0);
    send_beat(pps_pkg::CMD_REPORT, tick, '0, '0, '0, 3'd7, pps_pkg::OUTC_SUCCESS, '0);
    send_beat(pps_pkg::CMD_NONE, tick, '1, '1, '1, 3'd7, pps_pkg::OUTC_FAILURE_ALT, '1);
    go_idle();
    drain();

    // Zero cap becomes a sleep of one; the widest cap follows.
    write_cfg(pps_pkg::CFG_MAX_SLEEP, 32'd0);
    send_beat(pps_pkg::CMD_POLL, tick, '0, '0, '0, '0, '0, '0);
    go_idle();
    drain();
    write_cfg(pps_pkg::CFG_MAX_SLEEP, 32'hFFFF_FFFF);
    // Registration is refused while running.
    write_cfg(pps_pkg::CFG_RUNNING, 32'd1);
    send_beat(pps_pkg::CMD_REGISTER, tick, 32'd10, 32'd0, 32'd1, '0, '0, '0);
    go_idle();
    drain();

    // Two jobs share a due time, so the tie goes to the later slot; the
    // widest period and phase are covered too.
    write_cfg(pps_pkg::CFG_RUNNING, 32'd0);
    send_beat(pps_pkg::CMD_REGISTER, tick, 32'd20, 32'd0, 32'h1234_5678, '0, '0, '0);
    send_beat(pps_pkg::CMD_REGISTER, tick, 32'd30, 32'd0, 32'h0000_0001, '0, '0, '0);
    send_beat(pps_pkg::CMD_POLL, tick, '0, '0, '0, '0, '0, '0);
    send_beat(pps_pkg::CMD_REGISTER, tick, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              '0, '0, '0);
    send_beat(pps_pkg::CMD_POLL, tick, '0, '0, '0, '0, '0, '0);
    // Pending during init counts as failure; then init, pending and a late
    // success that skips missed periods.
    send_beat(pps_pkg::CMD_REPORT, tick, '0, '0, '0, 3'd1, pps_pkg::OUTC_PENDING, 32'd7);
    send_beat(pps_pkg::CMD_REPORT, tick, '0, '0, '0, 3'd0, pps_pkg::OUTC_SUCCESS, '0);
    send_beat(pps_pkg::CMD_REPORT, tick + 25, '0, '0, '0, 3'd0, pps_pkg::OUTC_PENDING,
              tick + 28);
    send_beat(pps_pkg::CMD_REPORT, tick + 95, '0, '0, '0, 3'd0, pps_pkg::OUTC_SUCCESS, '0);
    send_beat(pps_pkg::CMD_REPORT, tick + 99, '0, '0, '0, 3'd0,
              pps_pkg::OUTC_FAILURE_ALT, '0);
    send_beat(pps_pkg::CMD_REPORT, tick + 99, '0, '0, '0, 3'd1, pps_pkg::OUTC_FAILURE, '0);
    send_beat(pps_pkg::CMD_POLL, tick + 60, '0, '0, '0, '0, '0, '0);
    go_idle();
    drain();

    // Fill the table, then a refused register on the full table.
    write_cfg(pps_pkg::CFG_MAX_SLEEP, 32'd100);
    load_table(5);
    send_beat(pps_pkg::CMD_REGISTER, tick, 32'd5, 32'd0, '0, '0, '0, '0);
    go_idle();
    drain();

    // Long receiver hold-off while the sender keeps offering beats.
    write_cfg(pps_pkg::CFG_RUNNING, 32'd1);
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) poll_round(1'b0);
    go_idle();
    drain();

    // Random phases: each phase runs with its own sleep cap.
    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      case (ph_i)
        0: write_cfg(pps_pkg::CFG_MAX_SLEEP, 32'd1);
        1: write_cfg(pps_pkg::CFG_MAX_SLEEP, 32'hFFFF_FFFF);
        default: write_cfg(pps_pkg::CFG_MAX_SLEEP, $urandom_range(1, 500));
      endcase
      write_cfg(pps_pkg::CFG_RUNNING, $urandom_range(0, 1));
      sink_random = (ph_i != 2);
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(2'($urandom), $urandom, $urandom, $urandom, $urandom,
                    3'($urandom), 2'($urandom), $urandom);
        else
          poll_round(ph_i != 3);
      end
      go_idle();
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("** periodic_poll_scheduler_top: PASSED **");
    else
      $display("** periodic_poll_scheduler_top: FAILED **");
    $finish;
  end

endmodule
